// File: hw/rtl/ortp_pkg.sv
// Orthographic projection package: shared constants, register indexes and
// the screen configuration struct. No dependencies.
package ortp_pkg;

  localparam int unsigned SINE_TABLE_DEPTH   = 1024;
  localparam int unsigned TRIG_FRACTION_BITS = 15;

  // Angles are in 1/64 degree
  localparam int unsigned TURN_UNITS    = 23040;
  localparam int unsigned QUARTER_UNITS = 5760;
  localparam int unsigned ANGLE_W       = 18;

  // Pi in Q30 for the table build
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Division by 45 through a reciprocal: floor(2^24 / 45)
  localparam int unsigned RECIP_45    = 372827;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 19;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_CENTER_LON = 3'd0,
    REG_CENTER_LAT = 3'd1,
    REG_SCREEN_X   = 3'd2,
    REG_SCREEN_Y   = 3'd3,
    REG_RADIUS     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [12:0] cx;
    logic [12:0] cy;
    logic [15:0] radius;
  } screen_cfg_t;

endpackage

// File: hw/rtl/ortp_trig.sv
// Angle to sine lookup: turn reduction, rounded table index, registered ROM.
// Depends on ortp_pkg. Five register stages from angle to sine.
module ortp_trig #(
  parameter int unsigned DEPTH = ortp_pkg::SINE_TABLE_DEPTH,
  parameter int unsigned FRAC  = ortp_pkg::TRIG_FRACTION_BITS
) (
  input  logic                                  clk_i,
  input  logic signed [ortp_pkg::ANGLE_W-1:0]   angle_i,
  output logic signed [FRAC+1:0]                sine_o
);

  localparam int unsigned TW = FRAC + 2;
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned NW = 16 + IW;
  localparam int unsigned QW = NW - 9;
  localparam int unsigned MW = QW + ortp_pkg::RECIP_W;

  // Build one table entry with a truncated Taylor series in Q30, rounded to FRAC bits
  function automatic logic signed [TW-1:0] sine_entry(input int unsigned k);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    bit              neg;
    theta = (64'd2 * ortp_pkg::PI_Q30 * longint'(k)) / DEPTH;
    neg   = 1'b0;
    if (theta >= ortp_pkg::PI_Q30) begin
      neg   = 1'b1;
      theta = theta - ortp_pkg::PI_Q30;
    end
    if (theta > ortp_pkg::PI_Q30 / 2) begin
      theta = ortp_pkg::PI_Q30 - theta;
    end
    x2   = (theta * theta) >> 30;
    term = theta;
    sum  = theta;
    // Odd powers up to x^15 with alternating signs
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    if (FRAC < 30) begin
      v = (sum + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    end else begin
      v = sum;
    end
    return neg ? -TW'(v) : TW'(v);
  endfunction

  logic signed [TW-1:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    localparam logic signed [TW-1:0] Entry = sine_entry(k);
    assign rom[k] = Entry;
  end

  // Stage 1: fold the angle into one turn
  logic signed [ortp_pkg::ANGLE_W-1:0] a_ofs;
  logic [16:0] r0, r1, r2, r3;
  logic [14:0] w_q;

  always_comb begin
    a_ofs = angle_i + ortp_pkg::ANGLE_W'(3 * ortp_pkg::TURN_UNITS);
    r0    = a_ofs[16:0];
    r1    = (r0 >= 17'(4 * ortp_pkg::TURN_UNITS)) ? r0 - 17'(4 * ortp_pkg::TURN_UNITS) : r0;
    r2    = (r1 >= 17'(2 * ortp_pkg::TURN_UNITS)) ? r1 - 17'(2 * ortp_pkg::TURN_UNITS) : r1;
    r3    = (r2 >= 17'(ortp_pkg::TURN_UNITS)) ? r2 - 17'(ortp_pkg::TURN_UNITS) : r2;
  end

  always_ff @(posedge clk_i) begin
    w_q <= r3[14:0];
  end

  // Stage 2: scale to table units, add half a step
  logic [NW-1:0] num_q;

  always_ff @(posedge clk_i) begin
    num_q <= NW'(w_q) * NW'(DEPTH) + NW'(ortp_pkg::TURN_UNITS / 2);
  end

  // Stage 3: divide by 512 by shift, then by 45 through the reciprocal
  logic [QW-1:0] n_q;
  logic [MW-1:0] qm_q;

  always_ff @(posedge clk_i) begin
    n_q  <= num_q[NW-1:9];
    qm_q <= MW'(num_q[NW-1:9]) * MW'(ortp_pkg::RECIP_45);
  end

  // Stage 4: correct the quotient by one, wrap a full turn to entry zero
  logic [IW:0]   q0, q1;
  logic [QW-1:0] rem;
  logic [IW-1:0] idx_q;

  always_comb begin
    q0  = (IW + 1)'(qm_q >> ortp_pkg::RECIP_SHIFT);
    rem = n_q - QW'(q0) * QW'(45);
    q1  = (rem >= QW'(45)) ? q0 + (IW + 1)'(1) : q0;
  end

  always_ff @(posedge clk_i) begin
    idx_q <= (q1 >= (IW + 1)'(DEPTH)) ? '0 : q1[IW-1:0];
  end

  // Stage 5: table read
  logic signed [TW-1:0] sine_q;

  always_ff @(posedge clk_i) begin
    sine_q <= rom[idx_q];
  end

  assign sine_o = sine_q;

endmodule

// File: hw/rtl/ortp_math.sv
// Projection arithmetic: trig products, visibility, scaling, rounding and
// saturation over five register stages. Depends on ortp_pkg.
module ortp_math #(
  parameter int unsigned FRAC = ortp_pkg::TRIG_FRACTION_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic signed [FRAC+1:0]   sl0_i,
  input  logic signed [FRAC+1:0]   cl0_i,
  input  logic signed [FRAC+1:0]   sl_i,
  input  logic signed [FRAC+1:0]   cl_i,
  input  logic signed [FRAC+1:0]   sd_i,
  input  logic signed [FRAC+1:0]   cd_i,
  input  ortp_pkg::screen_cfg_t    cfg_i,
  output logic                     out_valid_o,
  output logic signed [15:0]       screen_x_o,
  output logic signed [15:0]       screen_y_o,
  output logic                     visible_o
);

  localparam int unsigned TW = FRAC + 2;
  localparam int unsigned PW = 2 * TW;
  localparam int unsigned SH = FRAC + 4;
  localparam int unsigned NUMW = FRAC + 22;
  localparam int unsigned RW = NUMW - SH + 1;

  // Trig product rounded half away from zero back to FRAC bits
  function automatic logic signed [TW-1:0] mul_t(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
    logic signed [PW-1:0] p;
    logic [PW-1:0]        m;
    p = a * b;
    m = p[PW-1] ? PW'(-p) : PW'(p);
    m = (m + (PW'(1) << (FRAC - 1))) >> FRAC;
    return p[PW-1] ? -TW'(m) : TW'(m);
  endfunction

  // Scale down by SH with rounding, then clamp to 16 bits
  function automatic logic signed [15:0] round_sat(input logic signed [NUMW-1:0] v);
    logic [NUMW-1:0]     m;
    logic signed [RW-1:0] r;
    m = v[NUMW-1] ? NUMW'(-v) : NUMW'(v);
    m = (m + (NUMW'(1) << (SH - 1))) >> SH;
    r = v[NUMW-1] ? -RW'(m) : RW'(m);
    if (r > RW'(32767)) begin
      return 16'sh7fff;
    end else if (r < -RW'(32768)) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  logic [4:0] v_q;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], in_valid_i};
    end
  end

  // Stage 1: two-factor products
  logic signed [TW-1:0] ss_q, cc_q, cs_q, sc_q, x1_q, cd1_q;

  always_ff @(posedge clk_i) begin
    ss_q  <= mul_t(sl0_i, sl_i);
    cc_q  <= mul_t(cl0_i, cl_i);
    cs_q  <= mul_t(cl0_i, sl_i);
    sc_q  <= mul_t(sl0_i, cl_i);
    x1_q  <= mul_t(cl_i, sd_i);
    cd1_q <= cd_i;
  end

  // Stage 2: third factor
  logic signed [TW-1:0] ss2_q, cs2_q, x2_q, ccd_q, scd_q;

  always_ff @(posedge clk_i) begin
    ccd_q <= mul_t(cc_q, cd1_q);
    scd_q <= mul_t(sc_q, cd1_q);
    ss2_q <= ss_q;
    cs2_q <= cs_q;
    x2_q  <= x1_q;
  end

  // Stage 3: visibility, y, and x times radius
  logic signed [TW:0]   cosc, y_d;
  logic                 vis3_q;
  logic signed [TW:0]   y_q;
  logic signed [NUMW-1:0] xr_q;

  always_comb begin
    cosc = (TW + 1)'(ss2_q) + (TW + 1)'(ccd_q);
    y_d  = (TW + 1)'(cs2_q) - (TW + 1)'(scd_q);
  end

  always_ff @(posedge clk_i) begin
    vis3_q <= !cosc[TW] && (cosc != '0);
    y_q    <= y_d;
    xr_q   <= NUMW'(x2_q) * NUMW'($signed({1'b0, cfg_i.radius}));
  end

  // Stage 4: y times radius, x centre added
  logic                   vis4_q;
  logic signed [NUMW-1:0] yr_q, numx_q;

  always_ff @(posedge clk_i) begin
    vis4_q <= vis3_q;
    yr_q   <= NUMW'(y_q) * NUMW'($signed({1'b0, cfg_i.radius}));
    numx_q <= $signed(NUMW'(cfg_i.cx) << (SH - 1)) + xr_q;
  end

  // Stage 5: y centre, round, clamp, zero hidden points
  logic signed [NUMW-1:0] numy;
  logic signed [15:0]     sx_q, sy_q;
  logic                   vis_q;

  assign numy = $signed(NUMW'(cfg_i.cy) << (SH - 1)) - yr_q;

  always_ff @(posedge clk_i) begin
    vis_q <= vis4_q;
    sx_q  <= vis4_q ? round_sat(numx_q) : '0;
    sy_q  <= vis4_q ? round_sat(numy) : '0;
  end

  assign out_valid_o = v_q[4];
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;
  assign visible_o   = vis_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> ##5 (v_q[4] == $past(in_valid_i, 5)))
    else $error("result strobe out of step with input");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !vis_q) |-> (sx_q == '0 && sy_q == '0))
    else $error("hidden point with nonzero position");

  a_vis_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |=> ##1 (vis_q == $past(vis3_q, 2)))
    else $error("visibility lost between stages");
`endif

endmodule

// File: hw/rtl/orthographic_projection_core.sv
// Orthographic projection top level: APB registers, six sine lookups and
// the projection datapath. Depends on ortp_pkg, ortp_trig, ortp_math.
//
//  channel   handshake              payload
//  --------  ---------------------  ------------------------------------
//  input     start, busy            longitude_i, latitude_i
//  result    result_valid_o         screen_x_o, screen_y_o, visible_o
//  config    psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One item per cycle; busy stays low. The result strobe for an item rises
// once it has passed five stages of angle reduction and table read, then
// five of products, scaling and rounding.
// Reset clears the configuration registers and the valid bits; no clearing pass.
// The receiver cannot stall, so the pipeline never holds.
module orthographic_projection_core #(
  parameter int unsigned SINE_TABLE_DEPTH   = ortp_pkg::SINE_TABLE_DEPTH,
  parameter int unsigned TRIG_FRACTION_BITS = ortp_pkg::TRIG_FRACTION_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            longitude_i,
  input  logic signed [13:0]            latitude_i,
  output logic                          result_valid_o,
  output logic signed [15:0]            screen_x_o,
  output logic signed [15:0]            screen_y_o,
  output logic                          visible_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ortp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned TW = TRIG_FRACTION_BITS + 2;
  localparam int unsigned AW = ortp_pkg::ANGLE_W;

  logic [14:0]        clon_q;
  logic signed [13:0] clat_q;
  logic [12:0]        cx_q, cy_q;
  logic [15:0]        radius_q;
  logic               wr_en;
  ortp_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = ortp_pkg::reg_idx_e'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clon_q   <= '0;
      clat_q   <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      radius_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        ortp_pkg::REG_CENTER_LON: clon_q   <= pwdata[14:0];
        ortp_pkg::REG_CENTER_LAT: clat_q   <= pwdata[13:0];
        ortp_pkg::REG_SCREEN_X:   cx_q     <= pwdata[12:0];
        ortp_pkg::REG_SCREEN_Y:   cy_q     <= pwdata[12:0];
        ortp_pkg::REG_RADIUS:     radius_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      ortp_pkg::REG_CENTER_LON: prdata = {17'd0, clon_q};
      ortp_pkg::REG_CENTER_LAT: prdata = {18'd0, clat_q};
      ortp_pkg::REG_SCREEN_X:   prdata = {19'd0, cx_q};
      ortp_pkg::REG_SCREEN_Y:   prdata = {19'd0, cy_q};
      ortp_pkg::REG_RADIUS:     prdata = {16'd0, radius_q};
      default:                  prdata = '0;
    endcase
  end

  // Accept an item every cycle
  logic       accept;
  logic [4:0] tv_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else begin
      tv_q <= {tv_q[3:0], accept};
    end
  end

  // Angles for the six lookups
  logic signed [AW-1:0] a_lat0, a_clat0, a_lat, a_clat, a_dlon, a_cdlon;

  always_comb begin
    a_lat0  = AW'(clat_q);
    a_clat0 = AW'(clat_q) + AW'(ortp_pkg::QUARTER_UNITS);
    a_lat   = AW'(latitude_i);
    a_clat  = AW'(latitude_i) + AW'(ortp_pkg::QUARTER_UNITS);
    a_dlon  = AW'(longitude_i) - $signed(AW'(clon_q));
    a_cdlon = a_dlon + AW'(ortp_pkg::QUARTER_UNITS);
  end

  logic signed [TW-1:0] sl0, cl0, sl, cl, sd, cd;

  ortp_trig #(.DEPTH(SINE_TABLE_DEPTH), .FRAC(TRIG_FRACTION_BITS)) u_sl0 (
    .clk_i(clk_i), .angle_i(a_lat0), .sine_o(sl0));
  ortp_trig #(.DEPTH(SINE_TABLE_DEPTH), .FRAC(TRIG_FRACTION_BITS)) u_cl0 (
    .clk_i(clk_i), .angle_i(a_clat0), .sine_o(cl0));
  ortp_trig #(.DEPTH(SINE_TABLE_DEPTH), .FRAC(TRIG_FRACTION_BITS)) u_sl (
    .clk_i(clk_i), .angle_i(a_lat), .sine_o(sl));
  ortp_trig #(.DEPTH(SINE_TABLE_DEPTH), .FRAC(TRIG_FRACTION_BITS)) u_cl (
    .clk_i(clk_i), .angle_i(a_clat), .sine_o(cl));
  ortp_trig #(.DEPTH(SINE_TABLE_DEPTH), .FRAC(TRIG_FRACTION_BITS)) u_sd (
    .clk_i(clk_i), .angle_i(a_dlon), .sine_o(sd));
  ortp_trig #(.DEPTH(SINE_TABLE_DEPTH), .FRAC(TRIG_FRACTION_BITS)) u_cd (
    .clk_i(clk_i), .angle_i(a_cdlon), .sine_o(cd));

  ortp_pkg::screen_cfg_t cfg;

  assign cfg.cx     = cx_q;
  assign cfg.cy     = cy_q;
  assign cfg.radius = radius_q;

  ortp_math #(.FRAC(TRIG_FRACTION_BITS)) u_math (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tv_q[4]),
    .sl0_i       (sl0),
    .cl0_i       (cl0),
    .sl_i        (sl),
    .cl_i        (cl),
    .sd_i        (sd),
    .cd_i        (cd),
    .cfg_i       (cfg),
    .out_valid_o (result_valid_o),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .visible_o   (visible_o)
  );

endmodule

// File: dv/ortp_checker.sv
// Projection checker: watches the item and result channels and the register
// writes, predicts each projected point and compares. Depends on ortp_pkg.
module ortp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] longitude_i,
  input  logic signed [13:0] latitude_i,
  input  logic               result_valid_o,
  input  logic signed [15:0] screen_x_o,
  input  logic signed [15:0] screen_y_o,
  input  logic               visible_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [ortp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 err_count,
  output int                 pending_points
);

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               vis;
  } point_t;

  localparam int TB = ortp_pkg::TRIG_FRACTION_BITS;
  localparam longint TURN = ortp_pkg::TURN_UNITS;
  localparam longint DEPTH = ortp_pkg::SINE_TABLE_DEPTH;
  localparam longint QUARTER = ortp_pkg::QUARTER_UNITS;

  longint sin_lut [ortp_pkg::SINE_TABLE_DEPTH];
  logic [14:0]        c_lon;
  logic signed [13:0] c_lat;
  logic [12:0]        c_sx, c_sy;
  logic [15:0]        c_rad;
  point_t             expected_points[$];

  assign pending_points = expected_points.size();

  // Build the sine table with the Q30 Taylor series
  initial begin
    longint unsigned theta, x2, term, sum, v;
    bit neg;
    err_count = 0;
    for (int k = 0; k < ortp_pkg::SINE_TABLE_DEPTH; k++) begin
      theta = (64'd2 * ortp_pkg::PI_Q30 * k) / DEPTH;
      neg = 0;
      if (theta >= ortp_pkg::PI_Q30) begin
        neg = 1;
        theta -= ortp_pkg::PI_Q30;
      end
      if (theta > ortp_pkg::PI_Q30 / 2) theta = ortp_pkg::PI_Q30 - theta;
      x2 = (theta * theta) >> 30;
      term = theta;
      sum = theta;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = (sum >= term) ? sum - term : 0;
        else sum += term;
      end
      v = (sum + (64'd1 << (29 - TB))) >> (30 - TB);
      sin_lut[k] = neg ? -longint'(v) : longint'(v);
    end
  end

  function automatic longint trig_at(longint a);
    longint w, idx;
    w = a % TURN;
    if (w < 0) w += TURN;
    idx = (w * DEPTH + TURN / 2) / TURN;
    if (idx >= DEPTH) idx -= DEPTH;
    return sin_lut[idx];
  endfunction

  function automatic longint round_away(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_away(a * b, TB);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Project one point with the current registers
  function automatic point_t project_point(longint lon, longint lat);
    longint dlon, sl0, cl0, sl, cl, sd, cd, cosc, x, y, nx, ny;
    point_t p;
    int sh;
    sh = TB + 4;
    dlon = lon - longint'(c_lon);
    sl0 = trig_at(longint'(c_lat));
    cl0 = trig_at(longint'(c_lat) + QUARTER);
    sl = trig_at(lat);
    cl = trig_at(lat + QUARTER);
    sd = trig_at(dlon);
    cd = trig_at(dlon + QUARTER);
    cosc = qmul(sl0, sl) + qmul(qmul(cl0, cl), cd);
    p = '0;
    if (cosc <= 0) return p;
    x = qmul(cl, sd);
    y = qmul(cl0, sl) - qmul(qmul(sl0, cl), cd);
    nx = (longint'(c_sx) <<< (sh - 1)) + x * longint'(c_rad);
    ny = (longint'(c_sy) <<< (sh - 1)) - y * longint'(c_rad);
    p.sx = 16'(clamp16(round_away(nx, sh)));
    p.sy = 16'(clamp16(round_away(ny, sh)));
    p.vis = 1'b1;
    return p;
  endfunction

  // Append one prediction at the tail
  task automatic append_point(point_t p);
    expected_points = {expected_points, p};
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Track registers, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    if (!rst_ni) begin
      c_lon <= '0;
      c_lat <= '0;
      c_sx <= '0;
      c_sy <= '0;
      c_rad <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ortp_pkg::reg_idx_e'(paddr[4:2]))
          ortp_pkg::REG_CENTER_LON: c_lon <= pwdata[14:0];
          ortp_pkg::REG_CENTER_LAT: c_lat <= pwdata[13:0];
          ortp_pkg::REG_SCREEN_X:   c_sx <= pwdata[12:0];
          ortp_pkg::REG_SCREEN_Y:   c_sy <= pwdata[12:0];
          ortp_pkg::REG_RADIUS:     c_rad <= pwdata[15:0];
          default: ;
        endcase
      end
      if (start && !busy)
        append_point(project_point(longitude_i, latitude_i));
      if (result_valid_o) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result", screen_x_o, 0);
        end else begin
          want = expected_points.pop_front();
          if (visible_o !== want.vis) report_mismatch("visible", visible_o, want.vis);
          if (screen_x_o !== want.sx) report_mismatch("screen_x", screen_x_o, want.sx);
          if (screen_y_o !== want.sy) report_mismatch("screen_y", screen_y_o, want.sy);
        end
      end
    end
  end
endmodule

// File: dv/tb_orthographic_projection_core.sv
// Projection testbench top: clock, reset, register setup, point stimulus and
// the verdict. Depends on ortp_pkg, ortp_checker and the projection core.
module tb_orthographic_projection_core;

  logic clk_i, rst_ni;
  logic start, busy;
  logic signed [15:0] longitude_i;
  logic signed [13:0] latitude_i;
  logic result_valid_o, visible_o;
  logic signed [15:0] screen_x_o, screen_y_o;
  logic psel, penable, pwrite, pready;
  logic [ortp_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int err_count, pending_points;

  orthographic_projection_core DUT (.*);
  ortp_checker u_checker (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic write_reg(ortp_pkg::reg_idx_e idx, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ortp_pkg::PADDR_W'(idx) << 2;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(negedge clk_i);
  endtask

  // Drain results, then let the pipeline settle
  task automatic drain();
    int guard;
    start <= 0;
    guard = 0;
    while (pending_points != 0 && guard < 10000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (14) @(negedge clk_i);
  endtask

  task automatic set_view(int lon0, int lat0, int sx, int sy, int rad);
    drain();
    write_reg(ortp_pkg::REG_CENTER_LON, 32'(lon0));
    write_reg(ortp_pkg::REG_CENTER_LAT, 32'(lat0));
    write_reg(ortp_pkg::REG_SCREEN_X, 32'(sx));
    write_reg(ortp_pkg::REG_SCREEN_Y, 32'(sy));
    write_reg(ortp_pkg::REG_RADIUS, 32'(rad));
  endtask

  // Present one item and hold it until it is taken
  task automatic send_point(int lon, int lat);
    start <= 1;
    longitude_i <= 16'(lon);
    latitude_i <= 14'(lat);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic gap(int n);
    start <= 0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic int rand_lon();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $signed(16'($urandom));
    return $urandom_range(0, 46080) - 23040;
  endfunction

  function automatic int rand_lat();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $signed(14'($urandom));
    return $urandom_range(0, 11520) - 5760;
  endfunction

  initial begin
    int burst;
    start = 0;
    longitude_i = 0;
    latitude_i = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    rst_ni = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Zero radius at reset: visible points land on the centre
    send_point(0, 0);
    send_point(11520, 0);
    set_view(0, 0, 4000, 3000, 16 * 200);
    // Field extremes, hidden points, wrap, beyond-pole latitudes
    send_point(-23040, 0);
    send_point(23040, -5760);
    send_point(-32768, -8192);
    send_point(32767, 8191);
    send_point(5760, 5760);
    send_point(-5760, -5760);
    send_point(11520, 1000);
    send_point(100, 7000);
    send_point(-100, -7000);
    send_point(2000, 3000);
    // Far off screen saturates both ways
    set_view(32767, -8192, 8191, 0, 65535);
    send_point(5760, 0);
    send_point(17280, -3000);
    send_point(0, 5760);
    send_point(23040, -5760);
    set_view(23040, 5760, 0, 8191, 65535);
    send_point(0, 0);
    send_point(-5760, 3000);
    send_point(5760, 3000);
    set_view(0, -5760, 8191, 8191, 0);
    send_point(1000, -4000);
    send_point(-1000, 0);

    // Random phases with fresh registers
    for (int ph = 0; ph < 11; ph++) begin
      case (ph % 4)
        0: set_view($urandom_range(0, 32767), $signed(14'($urandom)),
                    $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 65535));
        1: set_view($urandom_range(0, 23040), $urandom_range(0, 11520) - 5760,
                    4096, 4096, $urandom_range(0, 4000));
        2: set_view(0, 0, 0, 0, 65535);
        default: set_view(23040, -5760, 8191, 0, $urandom_range(0, 65535));
      endcase
      for (int n = 0; n < 150;) begin
        burst = $urandom_range(1, 30);
        for (int b = 0; b < burst && n < 150; b++, n++) send_point(rand_lon(), rand_lat());
        if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
      end
    end

    drain();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/ortp_pkg.sv
hw/rtl/ortp_trig.sv
hw/rtl/ortp_math.sv
hw/rtl/orthographic_projection_core.sv
dv/ortp_checker.sv
dv/tb_orthographic_projection_core.sv
